// ----- hdl/assert_macros.svh -----
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define DLTQ_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DLTQ_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- hdl/dltq_pkg.sv -----
// shared types and constants of the delta list timer queue
`default_nettype none

package dltq_pkg;

    localparam int unsigned SLOTS_DEFAULT = 16;
    localparam int unsigned MAX_OUT       = 16;

    localparam int unsigned DELTA_W   = 15;
    localparam int unsigned HANDLER_W = 8;
    localparam int unsigned ARG_W     = 16;
    localparam int unsigned KIND_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXPIRED  = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_REJECTED = 2'd2
    } kind_t;

    typedef struct packed {
        logic [DELTA_W-1:0]   delta;
        logic [HANDLER_W-1:0] handler;
        logic [ARG_W-1:0]     argument;
    } entry_t;

    typedef struct packed {
        logic [DELTA_W-1:0] diff;
        logic               borrow;
        logic               zero;
    } alu_res_t;

endpackage

`default_nettype wire

// ----- hdl/dltq_alu.sv -----
// shared subtract and compare unit for deltas
`default_nettype none

module dltq_alu
    import dltq_pkg::*;
(
    input  logic [DELTA_W-1:0] a,
    input  logic [DELTA_W-1:0] b,
    output alu_res_t           res
);

    logic [DELTA_W:0] wide_diff;

    assign wide_diff  = {1'b0, a} - {1'b0, b};
    assign res.diff   = wide_diff[DELTA_W-1:0];
    assign res.borrow = wide_diff[DELTA_W];
    assign res.zero   = (wide_diff[DELTA_W-1:0] == '0);

endmodule

`default_nettype wire

// ----- hdl/dltq_store.sv -----
// entry memory, one write and one registered read port
`default_nettype none

module dltq_store
    import dltq_pkg::*;
#(
    parameter  int unsigned SLOTS = SLOTS_DEFAULT,
    localparam int unsigned IW    = $clog2(SLOTS)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [IW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem_reg [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/delta_list_timer_queue.sv -----
// top level: sequencer of the delta list timer queue
//
//  channel | signals                                  | role
//  req     | req_valid req_ready mode delay handler   | tick or insert request in
//          | argument                                 |
//  rsp     | rsp_valid rsp_ready kind expired_handler | accepted, rejected or expired
//          | expired_argument last                    | entry out, last flagged
//
// req_ready is high only while the sequencer is idle; one request at a time.
// insert: walk to pos, shift of the cnt - pos entries behind it, place, result;
// the shift is skipped when the new entry lands at the end.
// tick: decrement walk to the first positive slot (the last slot when there is none),
// expiry scan, compaction; compaction is skipped when nothing or everything expired.
// each slot visit uses the single memory read port and the shared subtractor.
// a held rsp stalls the expiry scan; reset empties the queue at once.
`default_nettype none
`include "assert_macros.svh"

module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 mode,
    input  logic [DELTA_W-1:0]   delay,
    input  logic [HANDLER_W-1:0] handler,
    input  logic [ARG_W-1:0]     argument,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [KIND_W-1:0]    kind,
    output logic [HANDLER_W-1:0] expired_handler,
    output logic [ARG_W-1:0]     expired_argument,
    output logic                 last
);

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT,
        S_SHIFT_END,
        S_PLACE,
        S_RESULT,
        S_DEC,
        S_EMIT_START,
        S_EMIT,
        S_COMPACT,
        S_COMPACT_END
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [IW-1:0]        pos_reg, pos_next;
    logic [IW-1:0]        src_reg, src_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [DELTA_W-1:0]   t_reg, t_next;
    logic [HANDLER_W-1:0] hnd_reg, hnd_next;
    logic [ARG_W-1:0]     arg_reg, arg_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        laddr_reg;
    logic                 hold_valid_reg, hold_valid_next;
    logic [HANDLER_W-1:0] hold_h_reg, hold_h_next;
    logic [ARG_W-1:0]     hold_a_reg, hold_a_next;
    kind_t                kind_reg, kind_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    kind_t                rsp_kind_reg, rsp_kind_next;
    logic [HANDLER_W-1:0] rsp_h_reg, rsp_h_next;
    logic [ARG_W-1:0]     rsp_a_reg, rsp_a_next;
    logic                 rsp_last_reg, rsp_last_next;

    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    entry_t               mem_wdata;
    logic [IW-1:0]        mem_raddr;
    entry_t               mem_rdata;

    logic [DELTA_W-1:0]   alu_a;
    logic [DELTA_W-1:0]   alu_b;
    alu_res_t             alu;

    logic                 out_free;
    logic                 expiring;
    logic                 pos_at_end;

    dltq_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dltq_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu)
    );

    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign pos_at_end = (CW'(pos_reg) == cnt_reg);
    assign expiring   = (n_reg < cnt_reg) && (32'(n_reg) < MAX_OUT) && alu.zero;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        src_next        = src_reg;
        n_next          = n_reg;
        t_next          = t_reg;
        hnd_next        = hnd_reg;
        arg_next        = arg_reg;
        pend_next       = pend_reg;
        hold_valid_next = hold_valid_reg;
        hold_h_next     = hold_h_reg;
        hold_a_next     = hold_a_reg;
        kind_next       = kind_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_kind_next   = rsp_kind_reg;
        rsp_h_next      = rsp_h_reg;
        rsp_a_next      = rsp_a_reg;
        rsp_last_next   = rsp_last_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = mem_rdata;
        mem_raddr = '0;
        alu_a     = mem_rdata.delta;
        alu_b     = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    t_next   = delay;
                    hnd_next = handler;
                    arg_next = argument;
                    pos_next = '0;
                    if (mode)
                    begin
                        if (cnt_reg == CW'(SLOTS))
                        begin
                            kind_next  = KIND_REJECTED;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    else if (cnt_reg != '0)
                    begin
                        state_next = S_DEC;
                    end
                end
            end

            S_WALK:
            begin
                alu_a = t_reg;
                alu_b = mem_rdata.delta;
                if (pos_at_end)
                begin
                    state_next = S_PLACE;
                end
                else if (!alu.borrow)
                begin
                    t_next    = alu.diff;
                    pos_next  = pos_reg + 1'b1;
                    mem_raddr = pos_reg + 1'b1;
                end
                else
                begin
                    src_next   = IW'(cnt_reg - 1'b1);
                    pend_next  = 1'b0;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT, S_SHIFT_END:
            begin
                // moved entry keeps its absolute time: reduce by the new delta
                alu_b = t_reg;
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = laddr_reg + 1'b1;
                    if (laddr_reg == pos_reg)
                    begin
                        mem_wdata.delta = alu.diff;
                    end
                end
                if (state_reg == S_SHIFT)
                begin
                    mem_raddr = src_reg;
                    pend_next = 1'b1;
                    if (src_reg == pos_reg)
                    begin
                        state_next = S_SHIFT_END;
                    end
                    else
                    begin
                        src_next = src_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                mem_we             = 1'b1;
                mem_waddr          = pos_reg;
                mem_wdata.delta    = t_reg;
                mem_wdata.handler  = hnd_reg;
                mem_wdata.argument = arg_reg;
                cnt_next           = cnt_reg + 1'b1;
                kind_next          = KIND_ACCEPTED;
                state_next         = S_RESULT;
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_kind_next  = kind_reg;
                    rsp_h_next     = '0;
                    rsp_a_next     = '0;
                    rsp_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_DEC:
            begin
                alu_b = DELTA_W'(1);
                if (!alu.borrow)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = pos_reg;
                    mem_wdata.delta = alu.diff;
                    state_next      = S_EMIT_START;
                end
                else if (CW'(pos_reg) == cnt_reg - 1'b1)
                begin
                    state_next = S_EMIT_START;
                end
                else
                begin
                    pos_next  = pos_reg + 1'b1;
                    mem_raddr = pos_reg + 1'b1;
                end
            end

            S_EMIT_START:
            begin
                mem_raddr       = '0;
                n_next          = '0;
                hold_valid_next = 1'b0;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                // one expiry is held back until the next slot shows whether it is the last
                mem_raddr = IW'(n_reg);
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_kind_next  = KIND_EXPIRED;
                        rsp_h_next     = hold_h_reg;
                        rsp_a_next     = hold_a_reg;
                        rsp_last_next  = !expiring;
                    end
                    if (expiring)
                    begin
                        hold_valid_next = 1'b1;
                        hold_h_next     = mem_rdata.handler;
                        hold_a_next     = mem_rdata.argument;
                        n_next          = n_reg + 1'b1;
                        mem_raddr       = IW'(n_reg + 1'b1);
                    end
                    else
                    begin
                        hold_valid_next = 1'b0;
                        if (n_reg == cnt_reg)
                        begin
                            cnt_next   = '0;
                            state_next = S_IDLE;
                        end
                        else if (n_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            src_next   = IW'(n_reg);
                            pend_next  = 1'b0;
                            state_next = S_COMPACT;
                        end
                    end
                end
            end

            S_COMPACT, S_COMPACT_END:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = laddr_reg - IW'(n_reg);
                end
                if (state_reg == S_COMPACT)
                begin
                    mem_raddr = src_reg;
                    pend_next = 1'b1;
                    if (CW'(src_reg) == cnt_reg - 1'b1)
                    begin
                        state_next = S_COMPACT_END;
                    end
                    else
                    begin
                        src_next = src_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = cnt_reg - n_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        src_reg      <= src_next;
        n_reg        <= n_next;
        t_reg        <= t_next;
        hnd_reg      <= hnd_next;
        arg_reg      <= arg_next;
        laddr_reg    <= mem_raddr;
        hold_h_reg   <= hold_h_next;
        hold_a_reg   <= hold_a_next;
        kind_reg     <= kind_next;
        rsp_kind_reg <= rsp_kind_next;
        rsp_h_reg    <= rsp_h_next;
        rsp_a_reg    <= rsp_a_next;
        rsp_last_reg <= rsp_last_next;
    end

    assign req_ready        = (state_reg == S_IDLE);
    assign rsp_valid        = rsp_valid_reg;
    assign kind             = rsp_kind_reg;
    assign expired_handler  = rsp_h_reg;
    assign expired_argument = rsp_a_reg;
    assign last             = rsp_last_reg;

    `DLTQ_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CW'(SLOTS), "entry count above slot count")
    `DLTQ_ASSERT(a_full_reject, clk, rst_n, (req_valid && req_ready && mode && cnt_reg == CW'(SLOTS)) |=> (cnt_reg == $past(cnt_reg)), "full queue changed by insert")
    `DLTQ_ASSERT(a_walk_bound, clk, rst_n, (state_reg == S_WALK || state_reg == S_DEC) |-> (CW'(pos_reg) <= cnt_reg), "walk ran past the last entry")
    `DLTQ_ASSERT(a_idle_no_load, clk, rst_n, (state_reg == S_IDLE && !rsp_valid_reg) |=> !rsp_valid_reg, "response loaded while idle")

endmodule

`default_nettype wire

// ----- verif/dltq_checker.sv -----
// request mode codes and the response checker of the delta list timer queue
`timescale 1ns / 100ps

package timer_req_pkg;

    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_INSERT = 1'b1
    } req_mode_t;

endpackage

module dltq_checker
    import dltq_pkg::*;
    import timer_req_pkg::*;
#(
    parameter int unsigned DEPTH = SLOTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  logic                 mode,
    input  logic [DELTA_W-1:0]   delay,
    input  logic [HANDLER_W-1:0] handler,
    input  logic [ARG_W-1:0]     argument,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [HANDLER_W-1:0] expired_handler,
    input  logic [ARG_W-1:0]     expired_argument,
    input  logic                 last,
    output int                   failures,
    output int                   outstanding
);

    typedef struct {
        kind_t                kind;
        logic [HANDLER_W-1:0] handler;
        logic [ARG_W-1:0]     argument;
        logic                 last;
    } response_t;

    response_t            due_responses[$];
    logic [DELTA_W-1:0]   slot_delta[DEPTH];
    logic [HANDLER_W-1:0] slot_handler[DEPTH];
    logic [ARG_W-1:0]     slot_argument[DEPTH];
    int                   slot_used;
    int                   fail_count = 0;

    assign failures = fail_count;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        fail_count++;
    endtask

    function automatic void add_timer(input logic [DELTA_W-1:0] wait_ticks,
                                      input logic [HANDLER_W-1:0] h,
                                      input logic [ARG_W-1:0] a);
        logic [DELTA_W-1:0] left;
        int                 at;
        response_t          r;
        left       = wait_ticks;
        at         = 0;
        r.kind     = KIND_ACCEPTED;
        r.handler  = '0;
        r.argument = '0;
        r.last     = 1'b1;
        if (slot_used >= DEPTH)
        begin
            r.kind = KIND_REJECTED;
        end
        else
        begin
            while (at < slot_used && slot_delta[at] <= left)
            begin
                left = left - slot_delta[at];
                at++;
            end
            if (at < slot_used)
                slot_delta[at] = slot_delta[at] - left;
            for (int j = slot_used; j > at; j--)
            begin
                slot_delta[j]    = slot_delta[j-1];
                slot_handler[j]  = slot_handler[j-1];
                slot_argument[j] = slot_argument[j-1];
            end
            slot_delta[at]    = left;
            slot_handler[at]  = h;
            slot_argument[at] = a;
            slot_used++;
        end
        due_responses.push_back(r);
    endfunction

    function automatic void age_and_expire();
        int        n;
        bit        aged;
        response_t r;
        n    = 0;
        aged = 1'b0;
        // only the first positive delta ages
        for (int j = 0; j < slot_used; j++)
        begin
            if (!aged && slot_delta[j] != '0)
            begin
                slot_delta[j] = slot_delta[j] - 1'b1;
                aged          = 1'b1;
            end
        end
        while (n < slot_used && n < MAX_OUT && slot_delta[n] == '0)
            n++;
        for (int k = 0; k < n; k++)
        begin
            r.kind     = KIND_EXPIRED;
            r.handler  = slot_handler[k];
            r.argument = slot_argument[k];
            r.last     = (k == n - 1);
            due_responses.push_back(r);
        end
        for (int j = n; j < slot_used; j++)
        begin
            slot_delta[j-n]    = slot_delta[j];
            slot_handler[j-n]  = slot_handler[j];
            slot_argument[j-n] = slot_argument[j];
        end
        slot_used = slot_used - n;
    endfunction

    task automatic check_response();
        response_t want;
        if (due_responses.size() == 0)
        begin
            report_mismatch($sformatf("response kind %0d with nothing outstanding", kind));
        end
        else
        begin
            want = due_responses.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
            if (expired_handler !== want.handler)
                report_mismatch($sformatf("expired_handler %0h, want %0h",
                                          expired_handler, want.handler));
            if (expired_argument !== want.argument)
                report_mismatch($sformatf("expired_argument %0h, want %0h",
                                          expired_argument, want.argument));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used = 0;
            due_responses.delete();
            outstanding <= 0;
        end
        else
        begin
            // responses first: one accepted alongside a request belongs to an older request
            if (rsp_valid && rsp_ready)
                check_response();
            if (req_valid && req_ready)
            begin
                if (mode == REQ_INSERT)
                    add_timer(delay, handler, argument);
                else
                    age_and_expire();
            end
            outstanding <= due_responses.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// stimulus, idling and verdict for the delta list timer queue
`timescale 1ns / 100ps

module tb;

    import dltq_pkg::*;
    import timer_req_pkg::*;

    localparam int RANDOM_REQUESTS = 185;
    localparam int QUIET_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 60;

    logic                 clk              = 1'b0;
    logic                 rst_n            = 1'b0;
    logic                 req_valid        = 1'b0;
    logic                 req_ready;
    logic                 mode             = REQ_TICK;
    logic [DELTA_W-1:0]   delay            = '0;
    logic [HANDLER_W-1:0] handler          = '0;
    logic [ARG_W-1:0]     argument         = '0;
    logic                 rsp_valid;
    logic                 rsp_ready        = 1'b0;
    logic [KIND_W-1:0]    kind;
    logic [HANDLER_W-1:0] expired_handler;
    logic [ARG_W-1:0]     expired_argument;
    logic                 last;

    int failures;
    int outstanding;
    int quiet_cycles = 0;
    int idle_pct     = 20;
    int stall_pct    = 25;
    int ready_hold   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    delta_list_timer_queue dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .mode             (mode),
        .delay            (delay),
        .handler          (handler),
        .argument         (argument),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .kind             (kind),
        .expired_handler  (expired_handler),
        .expired_argument (expired_argument),
        .last             (last)
    );

    dltq_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .mode             (mode),
        .delay            (delay),
        .handler          (handler),
        .argument         (argument),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .kind             (kind),
        .expired_handler  (expired_handler),
        .expired_argument (expired_argument),
        .last             (last),
        .failures         (failures),
        .outstanding      (outstanding)
    );

    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DELTA_W-1:0] random_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return DELTA_W'($urandom_range(0, 32767));
        if (r < 20)
            return '0;
        if (r < 85)
            return DELTA_W'($urandom_range(1, 6));
        return DELTA_W'($urandom_range(7, 40));
    endfunction

    task automatic send_request(input req_mode_t m, input logic [DELTA_W-1:0] d,
                                input logic [HANDLER_W-1:0] h, input logic [ARG_W-1:0] a);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = pause_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        mode      <= m;
        delay     <= d;
        handler   <= h;
        argument  <= a;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            rsp_ready  <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
                ready_hold <= pause_length();
        end
        if ($urandom_range(0, 199) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pct <= 0;
                1:       stall_pct <= 10;
                2:       stall_pct <= 25;
                default: stall_pct <= 60;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int        insert_pct;
        req_mode_t m;
        insert_pct = 50;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // tick on an empty queue, zero deltas, extremes, ties and a middle insert
        send_request(REQ_TICK,   '0,        8'h00, 16'h0000);
        send_request(REQ_INSERT, '0,        8'h00, 16'h0000);
        send_request(REQ_INSERT, '0,        8'hFF, 16'hFFFF);
        send_request(REQ_TICK,   '1,        8'hFF, 16'hFFFF);
        send_request(REQ_INSERT, 15'h7FFF,  8'hA5, 16'h5A5A);
        send_request(REQ_INSERT, 15'd1,     8'h5A, 16'hA5A5);
        send_request(REQ_INSERT, 15'd1,     8'h3C, 16'hC3C3);
        send_request(REQ_INSERT, 15'd3,     8'h01, 16'h8000);
        send_request(REQ_TICK,   '0,        8'h00, 16'h0000);
        wait_for_drain();

        // fill to capacity, overflow, then one tick expiring the whole head
        for (int i = 0; i < 14; i++)
            send_request(REQ_INSERT, '0, HANDLER_W'(i + 16), ARG_W'(16'h1000 + i));
        send_request(REQ_INSERT, 15'd5, 8'h77, 16'h7777);
        send_request(REQ_TICK, '0, 8'h00, 16'h0000);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 16 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 30;
                    1:       insert_pct = 50;
                    2:       insert_pct = 65;
                    default: insert_pct = 85;
                endcase
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            if (i == 60 || i == 130)
                wait_for_drain();
            m = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_TICK;
            send_request(m, random_delay(), HANDLER_W'($urandom_range(0, 255)),
                         ARG_W'($urandom_range(0, 65535)));
        end

        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
